// ----- hdl/svp_pkg.sv -----
// Shared types, constants and state codes of the stepper velocity PI controller.
package svp_pkg;

	// Timer period width and derived saturation mask
	localparam int PERIOD_BITS = 32;
	localparam int QUO_W       = 40;
	localparam logic [QUO_W-1:0] PMASK_Q = (QUO_W'(1) << PERIOD_BITS) - QUO_W'(1);

	// Serial multiplier: accumulator high part and full product width
	localparam int ACC_W  = 27;
	localparam int PROD_W = ACC_W + 32;
	localparam logic [3:0] MUL_LAST = 4'd15;

	// Serial divider: two quotient bits per cycle
	localparam logic [4:0] DIV_LAST = 5'd19;

	// Register map (word index)
	localparam int PADDR_W = 5;
	localparam logic [2:0] REG_SETPOINT  = 3'd0;
	localparam logic [2:0] REG_GAIN_NOW  = 3'd1;
	localparam logic [2:0] REG_GAIN_LAST = 3'd2;
	localparam logic [2:0] REG_MAX_FREQ  = 3'd3;
	localparam logic [2:0] REG_MIN_FREQ  = 3'd4;
	localparam logic [2:0] REG_CLOCK_HZ  = 3'd5;
	localparam logic [2:0] REG_DIR_INV   = 3'd6;

	// Register reset values
	localparam logic [30:0] MAX_FREQ_RST = 31'd2304000;
	localparam logic [30:0] MIN_FREQ_RST = 31'd5120;
	localparam logic [31:0] CLOCK_HZ_RST = 32'd84000000;

	// Status of a serial arithmetic unit
	typedef struct packed {
		logic busy;
		logic done;
	} svp_sts_t;

	// Controller sequence
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_RND,
		ST_SUM,
		ST_CLP,
		ST_DIV,
		ST_FIN
	} svp_state_t;

endpackage

// ----- hdl/svp_mul.sv -----
// Serial dual multiplier: op_a*gain_a + op_b*gain_b, two multiplier bits per cycle.
module svp_mul import svp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [31:0]       op_a,
	input  logic signed [31:0]       op_b,
	input  logic signed [23:0]       gain_a,
	input  logic signed [23:0]       gain_b,
	output svp_sts_t                 sts,
	output logic signed [PROD_W-1:0] product
);

	logic                    busy_q;
	logic [3:0]              cnt_q;
	logic signed [ACC_W-1:0] acc_q;
	logic [31:0]             lo_q;
	logic [31:0]             a_q;
	logic [31:0]             b_q;

	logic signed [ACC_W-1:0] ga;
	logic signed [ACC_W-1:0] gb;
	logic signed [ACC_W-1:0] t0;
	logic signed [ACC_W-1:0] h0;
	logic signed [ACC_W-1:0] t1;
	logic signed [ACC_W-1:0] h1;
	logic                    last;

	// Two shift-add steps; the top multiplier bit carries negative weight
	always_comb begin
		ga   = ACC_W'(gain_a);
		gb   = ACC_W'(gain_b);
		last = (cnt_q == MUL_LAST);
		t0   = acc_q + (a_q[0] ? ga : '0) + (b_q[0] ? gb : '0);
		h0   = t0 >>> 1;
		t1   = h0 + (a_q[1] ? (last ? -ga : ga) : '0) + (b_q[1] ? (last ? -gb : gb) : '0);
		h1   = t1 >>> 1;
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == MUL_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Operand and partial product shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= op_a;
			b_q   <= op_b;
			acc_q <= '0;
			lo_q  <= '0;
		end else if (busy_q) begin
			acc_q <= h1;
			lo_q  <= {t1[0], t0[0], lo_q[31:2]};
			a_q   <= {2'b00, a_q[31:2]};
			b_q   <= {2'b00, b_q[31:2]};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == MUL_LAST);
	assign product  = {acc_q, lo_q};

endmodule

// ----- hdl/svp_div.sv -----
// Serial restoring divider, 40-bit dividend by 31-bit divisor, two quotient bits per cycle.
module svp_div import svp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [QUO_W-1:0] dividend,
	input  logic [30:0]      divisor,
	output svp_sts_t         sts,
	output logic [QUO_W-1:0] quotient
);

	logic             busy_q;
	logic [4:0]       cnt_q;
	logic [31:0]      rem_q;
	logic [QUO_W-1:0] quo_q;
	logic [30:0]      dv_q;

	logic [31:0]      r0;
	logic [31:0]      rr0;
	logic [31:0]      r1;
	logic [31:0]      rr1;
	logic             ge0;
	logic             ge1;
	logic [QUO_W-1:0] d0;

	// Two shift-compare-subtract steps
	always_comb begin
		r0  = {rem_q[30:0], quo_q[QUO_W-1]};
		ge0 = (r0 >= {1'b0, dv_q});
		rr0 = ge0 ? (r0 - {1'b0, dv_q}) : r0;
		d0  = {quo_q[QUO_W-2:0], ge0};
		r1  = {rr0[30:0], d0[QUO_W-1]};
		ge1 = (r1 >= {1'b0, dv_q});
		rr1 = ge1 ? (r1 - {1'b0, dv_q}) : r1;
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == DIV_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dv_q  <= divisor;
		end else if (busy_q) begin
			rem_q <= rr1;
			quo_q <= {d0[QUO_W-2:0], ge1};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = busy_q && (cnt_q == DIV_LAST);
	assign quotient = quo_q;

endmodule

// ----- hdl/stepper_velocity_pi_period.sv -----
// Top level of the stepper velocity PI controller with timer period output.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  measured_speed
//   output    out        out_valid / out_stall direction, period_count, compare_value,
//                                             drive_freq, saturated, stopped
//   config    in         APB psel/penable     paddr, pwdata, prdata
//
// A word is taken only while idle; it passes the serial multiply, rounding, sum,
// clamp and the serial divide for the period, and the divide is skipped when the
// new frequency is zero.
// The output register holds a result under out_stall; a new word is taken meanwhile,
// and its result waits in the final step until the register is free.
// Reset restores the register defaults and clears frequency and previous error.
module stepper_velocity_pi_period import svp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   measured_speed,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 direction,
	output logic [31:0]          period_count,
	output logic [31:0]          compare_value,
	output logic signed [31:0]   drive_freq,
	output logic                 saturated,
	output logic                 stopped,
	// configuration port
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [PADDR_W-1:0]   paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	// Configuration registers
	logic signed [31:0] setpoint_q;
	logic signed [23:0] gain_now_q;
	logic signed [23:0] gain_last_q;
	logic [30:0]        max_freq_q;
	logic [30:0]        min_freq_q;
	logic [31:0]        clock_hz_q;
	logic               dir_inv_q;

	// Controller state and working registers
	svp_state_t         state_q;
	svp_state_t         state_d;
	logic signed [31:0] df_q;
	logic signed [31:0] prev_q;
	logic signed [31:0] err_q;
	logic signed [34:0] rnd_q;
	logic signed [35:0] sum_q;
	logic               sign_q;
	logic               sat_q;
	logic               stop_q;

	// Output register
	logic               out_valid_q;
	logic               dir_q;
	logic [31:0]        period_q;
	logic [31:0]        cmp_q;
	logic signed [31:0] freq_q;
	logic               osat_q;
	logic               ostop_q;

	// Unit interfaces
	svp_sts_t            mul_sts;
	svp_sts_t            div_sts;
	logic signed [PROD_W-1:0] product;
	logic [QUO_W-1:0]    quotient;
	logic                mul_start;
	logic                div_start;

	// Datapath combinational values
	logic                cfg_wr;
	logic                accept;
	logic                load_out;
	logic signed [32:0]  diff;
	logic signed [31:0]  err_sat;
	logic signed [PROD_W-1:0] prod_rnd;
	logic [35:0]         mag;
	logic                sign_c;
	logic                over;
	logic                under;
	logic signed [31:0]  newf;
	logic [30:0]         div_mag;
	logic                clr_prev;
	logic [QUO_W-1:0]    q_m1;
	logic [31:0]         period_c;
	logic [32:0]         period_p1;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= '0;
			gain_now_q  <= '0;
			gain_last_q <= '0;
			max_freq_q  <= MAX_FREQ_RST;
			min_freq_q  <= MIN_FREQ_RST;
			clock_hz_q  <= CLOCK_HZ_RST;
			dir_inv_q   <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				REG_SETPOINT:  setpoint_q  <= pwdata;
				REG_GAIN_NOW:  gain_now_q  <= pwdata[23:0];
				REG_GAIN_LAST: gain_last_q <= pwdata[23:0];
				REG_MAX_FREQ:  max_freq_q  <= pwdata[30:0];
				REG_MIN_FREQ:  min_freq_q  <= pwdata[30:0];
				REG_CLOCK_HZ:  clock_hz_q  <= pwdata;
				REG_DIR_INV:   dir_inv_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (paddr[4:2])
			REG_SETPOINT:  prdata = setpoint_q;
			REG_GAIN_NOW:  prdata = 32'(gain_now_q);
			REG_GAIN_LAST: prdata = 32'(gain_last_q);
			REG_MAX_FREQ:  prdata = {1'b0, max_freq_q};
			REG_MIN_FREQ:  prdata = {1'b0, min_freq_q};
			REG_CLOCK_HZ:  prdata = clock_hz_q;
			REG_DIR_INV:   prdata = {31'd0, dir_inv_q};
			default:       prdata = '0;
		endcase
	end

	// Error with saturation to the 32-bit range
	always_comb begin
		diff = 33'(setpoint_q) - 33'(measured_speed);
		if (!diff[32] && diff[31]) begin
			err_sat = 32'sh7FFF_FFFF;
		end else if (diff[32] && !diff[31]) begin
			err_sat = 32'sh8000_0000;
		end else begin
			err_sat = diff[31:0];
		end
	end

	// Round the product sum to Q27.8, ties up
	assign prod_rnd = product + PROD_W'(24'h80_0000);

	// Clamp, deadband and divisor selection
	always_comb begin
		mag      = sum_q[35] ? 36'(-sum_q) : 36'(sum_q);
		sign_c   = !sum_q[35] && (sum_q != '0);
		over     = mag > {5'd0, max_freq_q};
		under    = mag < {5'd0, min_freq_q};
		if (over) begin
			newf    = sign_c ? $signed({1'b0, max_freq_q}) : -$signed({1'b0, max_freq_q});
			div_mag = max_freq_q;
		end else if (under) begin
			newf    = '0;
			div_mag = '0;
		end else begin
			newf    = sum_q[31:0];
			div_mag = mag[30:0];
		end
		clr_prev = over && ((sign_c && !err_q[31] && (err_q != '0)) || (!sign_c && err_q[31]));
	end

	// Period from quotient, saturated to the timer width
	always_comb begin
		q_m1 = quotient - QUO_W'(1);
		if (stop_q) begin
			period_c = PMASK_Q[31:0];
		end else if (quotient == '0) begin
			period_c = '0;
		end else if (q_m1 > PMASK_Q) begin
			period_c = PMASK_Q[31:0];
		end else begin
			period_c = q_m1[31:0];
		end
		period_p1 = {1'b0, period_c} + 33'd1;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign load_out = (state_q == ST_FIN) && (!out_valid_q || !out_stall);

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and unit starts
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_sts.done) begin
					state_d = ST_RND;
				end
			end
			ST_RND: state_d = ST_SUM;
			ST_SUM: state_d = ST_CLP;
			ST_CLP: begin
				if (div_mag == '0) begin
					state_d = ST_FIN;
				end else begin
					div_start = 1'b1;
					state_d   = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_sts.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller state: frequency and previous error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			df_q   <= '0;
			prev_q <= '0;
		end else if (state_q == ST_CLP) begin
			df_q   <= newf;
			prev_q <= clr_prev ? 32'sd0 : err_q;
		end
	end

	// Working registers along the sequence
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: err_q <= err_sat;
			ST_RND:  rnd_q <= prod_rnd[PROD_W-1:24];
			ST_SUM:  sum_q <= 36'(df_q) + 36'(rnd_q);
			ST_CLP: begin
				sign_q <= sign_c;
				sat_q  <= over;
				stop_q <= (div_mag == '0);
			end
			default: ;
		endcase
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load_out) begin
			dir_q    <= !(sign_q ^ dir_inv_q);
			period_q <= period_c;
			cmp_q    <= period_p1[32:1];
			freq_q   <= df_q;
			osat_q   <= sat_q;
			ostop_q  <= stop_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign direction     = dir_q;
	assign period_count  = period_q;
	assign compare_value = cmp_q;
	assign drive_freq    = freq_q;
	assign saturated     = osat_q;
	assign stopped       = ostop_q;

	svp_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.op_a    (err_sat),
		.op_b    (prev_q),
		.gain_a  (gain_now_q),
		.gain_b  (gain_last_q),
		.sts     (mul_sts),
		.product (product)
	);

	svp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({clock_hz_q, 8'd0}),
		.divisor  (div_mag),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// Multiplier runs only while the sequence waits on it
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_sts.busy |-> state_q == ST_MUL)
		else $error("multiplier busy outside multiply step");

	// Divider runs only while the sequence waits on it
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.busy |-> state_q == ST_DIV)
		else $error("divider busy outside divide step");

	// A stopped result carries the all-ones period
	a_stop_period: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ostop_q |-> period_q == PMASK_Q[31:0])
		else $error("stopped result without saturated period");

	// A loaded result is not lost while the output is stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q)
		else $error("held result dropped under stall");

endmodule
